FILE: src/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared types and arithmetic for the segment closest-points pipe
// Payload structs, the side record that travels with each pair, and the
// split wide multiply used for the 136-bit cross terms.
// ----------------------------------------------------------------------------
package scp_pkg;

   localparam int CW     = 32;          // coordinate width
   localparam int FB     = 16;          // coordinate fraction bits
   localparam int PB     = 16;          // parameter fraction bits
   localparam int PW     = PB + 1;      // parameter width, one included
   localparam int LIM_W  = 32;          // degenerate limit register width
   localparam int DW     = CW + 1;      // difference vector component
   localparam int PROD_W = 2 * DW;      // one component product
   localparam int DOT_W  = PROD_W + 2;  // sum of three products
   localparam int HW     = DOT_W / 2;   // half of a dot product
   localparam int QW     = 2 * DOT_W;   // product of two dot products

   localparam int DIV_LAT = PB + 1;     // divider stages

   localparam logic [PW-1:0] PONE = {1'b1, {PB{1'b0}}};

   // where the second divider's quotient goes
   localparam logic SEL_S = 1'b0;
   localparam logic SEL_T = 1'b1;

   typedef struct packed {
      logic signed [CW-1:0] seg0_start_x;
      logic signed [CW-1:0] seg0_start_y;
      logic signed [CW-1:0] seg0_start_z;
      logic signed [CW-1:0] seg0_end_x;
      logic signed [CW-1:0] seg0_end_y;
      logic signed [CW-1:0] seg0_end_z;
      logic signed [CW-1:0] seg1_start_x;
      logic signed [CW-1:0] seg1_start_y;
      logic signed [CW-1:0] seg1_start_z;
      logic signed [CW-1:0] seg1_end_x;
      logic signed [CW-1:0] seg1_end_y;
      logic signed [CW-1:0] seg1_end_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] closest0_x;
      logic signed [CW-1:0] closest0_y;
      logic signed [CW-1:0] closest0_z;
      logic signed [CW-1:0] closest1_x;
      logic signed [CW-1:0] closest1_y;
      logic signed [CW-1:0] closest1_z;
      logic [PW-1:0]        param_s;
      logic [PW-1:0]        param_t;
   } rsp_type;

   typedef struct packed {
      logic [2:0][CW-1:0] p0;
      logic [2:0][CW-1:0] p1;
      logic [2:0][DW-1:0] d1;
      logic [2:0][DW-1:0] d2;
      logic [DOT_W-1:0]   a;
      logic [DOT_W-1:0]   b;
      logic [DOT_W-1:0]   c;
      logic [DOT_W-1:0]   e;
      logic [DOT_W-1:0]   f;
      logic               adeg;
      logic               edeg;
      logic [PW-1:0]      s;
      logic [PW-1:0]      t;
      logic               sel;
   } side_type;

   typedef struct packed {
      logic signed [2*HW-1:0] hh;
      logic signed [2*HW:0]   hl;
      logic signed [2*HW:0]   lh;
      logic [2*HW-1:0]        ll;
   } pp_type;

   // partial products of two signed dot-product values, each about 34x34
   function automatic pp_type wide_pp(input logic signed [DOT_W-1:0] x,
                                      input logic signed [DOT_W-1:0] y);
      pp_type p;
      p.hh = $signed(x[DOT_W-1:HW]) * $signed(y[DOT_W-1:HW]);
      p.hl = $signed(x[DOT_W-1:HW]) * $signed({1'b0, y[HW-1:0]});
      p.lh = $signed({1'b0, x[HW-1:0]}) * $signed(y[DOT_W-1:HW]);
      p.ll = x[HW-1:0] * y[HW-1:0];
      return p;
   endfunction

   function automatic logic signed [QW-1:0] wide_sum(input pp_type p);
      return (QW'(p.hh) <<< (2 * HW)) + (QW'(p.hl) <<< HW)
           + (QW'(p.lh) <<< HW) + QW'(p.ll);
   endfunction

endpackage

FILE: src/segment_segment_closest_points.sv
// ----------------------------------------------------------------------------
// segment_segment_closest_points: closest points between two 3D segments
// Fully pipelined; one segment pair per clock, results in fixed order.
// ----------------------------------------------------------------------------
// A new pair can be started on every clock: busy stays low, and each result
// appears on rsp_data with a one-cycle rsp_valid strobe, in start order. The
// receiver has no way to hold results, so it must take every strobe. The
// latency is set by the two 17-stage clamped dividers (s first, then t or the
// re-clamped s), plus the dot-product, wide cross term, selection and output
// stages. degenerate_limit is written through csr_*, which is always ready;
// write it only while no pair is in flight.
module segment_segment_closest_points (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  scp_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output scp_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [scp_pkg::LIM_W-1:0]     csr_data
);

   localparam int TAIL_LAT = 3 + scp_pkg::DIV_LAT + 2;

   logic [scp_pkg::LIM_W-1:0] limit_ff;
   logic front_valid, cross_valid, div1_valid, sel_valid, div2_valid;
   scp_pkg::side_type front_side, cross_side, div1_side, sel_side, div2_side;
   logic signed [scp_pkg::QW-1:0] cross_num, cross_den, sel_num, sel_den;
   logic [scp_pkg::PW-1:0] div1_q, div2_q;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   scp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_data),
      .out_valid (front_valid),
      .out_side  (front_side)
   );

   scp_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .limit     (limit_ff),
      .out_valid (cross_valid),
      .out_num   (cross_num),
      .out_den   (cross_den),
      .out_side  (cross_side)
   );

   scp_div u_div_s (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cross_valid),
      .in_num    (cross_num),
      .in_den    (cross_den),
      .in_side   (cross_side),
      .out_valid (div1_valid),
      .out_q     (div1_q),
      .out_side  (div1_side)
   );

   scp_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div1_valid),
      .in_q      (div1_q),
      .in_side   (div1_side),
      .out_valid (sel_valid),
      .out_num   (sel_num),
      .out_den   (sel_den),
      .out_side  (sel_side)
   );

   scp_div u_div_t (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_num    (sel_num),
      .in_den    (sel_den),
      .in_side   (sel_side),
      .out_valid (div2_valid),
      .out_q     (div2_q),
      .out_side  (div2_side)
   );

   scp_point u_point (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div2_valid),
      .in_q      (div2_q),
      .in_side   (div2_side),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

`ifndef SYNTHESIS
   // every transaction leaving the first divider reaches the output on time
   a_tail_latency : assert property (@(posedge clock) disable iff (reset)
      div1_valid |-> ##TAIL_LAT rsp_valid)
      else $error("transaction lost between first divider and output");

   a_param_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.param_s <= scp_pkg::PONE)
                 && (rsp_data.param_t <= scp_pkg::PONE))
      else $error("parameter outside [0,1]");

   a_reset_flush : assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");
`endif

endmodule

FILE: src/scp_front.sv
// ----------------------------------------------------------------------------
// scp_front: difference vectors and the five dot products
// Three stages: differences, component products, sums.
// ----------------------------------------------------------------------------
module scp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  scp_pkg::req_type  in_req,
   output logic              out_valid,
   output scp_pkg::side_type out_side
);

   localparam int DOT_A = 0;
   localparam int DOT_E = 1;
   localparam int DOT_F = 2;
   localparam int DOT_C = 3;
   localparam int DOT_B = 4;
   localparam int N_DOT = 5;

   logic v1_ff, v2_ff, v3_ff;

   logic [2:0][scp_pkg::CW-1:0] q0, q1;
   logic [2:0][scp_pkg::CW-1:0] p0_in, p1_in, p0_ff, p1_ff, p0_2_ff, p1_2_ff;
   logic [2:0][scp_pkg::DW-1:0] d1_in, d2_in, r_in, d1_ff, d2_ff, r_ff;
   logic [2:0][scp_pkg::DW-1:0] d1_2_ff, d2_2_ff;
   logic [N_DOT-1:0][2:0][scp_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic [N_DOT-1:0][scp_pkg::DOT_W-1:0]       dot_in;
   scp_pkg::side_type side_in, side_ff;

   always_comb begin
      p0_in[0] = in_req.seg0_start_x;
      p0_in[1] = in_req.seg0_start_y;
      p0_in[2] = in_req.seg0_start_z;
      q0[0]    = in_req.seg0_end_x;
      q0[1]    = in_req.seg0_end_y;
      q0[2]    = in_req.seg0_end_z;
      p1_in[0] = in_req.seg1_start_x;
      p1_in[1] = in_req.seg1_start_y;
      p1_in[2] = in_req.seg1_start_z;
      q1[0]    = in_req.seg1_end_x;
      q1[1]    = in_req.seg1_end_y;
      q1[2]    = in_req.seg1_end_z;
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = {q0[i][scp_pkg::CW-1], q0[i]} - {p0_in[i][scp_pkg::CW-1], p0_in[i]};
         d2_in[i] = {q1[i][scp_pkg::CW-1], q1[i]} - {p1_in[i][scp_pkg::CW-1], p1_in[i]};
         r_in[i]  = {p0_in[i][scp_pkg::CW-1], p0_in[i]}
                  - {p1_in[i][scp_pkg::CW-1], p1_in[i]};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[DOT_A][i] = $signed(d1_ff[i]) * $signed(d1_ff[i]);
         prod_in[DOT_E][i] = $signed(d2_ff[i]) * $signed(d2_ff[i]);
         prod_in[DOT_F][i] = $signed(d2_ff[i]) * $signed(r_ff[i]);
         prod_in[DOT_C][i] = $signed(d1_ff[i]) * $signed(r_ff[i]);
         prod_in[DOT_B][i] = $signed(d1_ff[i]) * $signed(d2_ff[i]);
      end
   end

   always_comb begin
      for (int k = 0; k < N_DOT; k++) begin
         dot_in[k] = scp_pkg::DOT_W'($signed(prod_ff[k][0]))
                   + scp_pkg::DOT_W'($signed(prod_ff[k][1]))
                   + scp_pkg::DOT_W'($signed(prod_ff[k][2]));
      end
      side_in      = '0;
      side_in.p0   = p0_2_ff;
      side_in.p1   = p1_2_ff;
      side_in.d1   = d1_2_ff;
      side_in.d2   = d2_2_ff;
      side_in.a    = dot_in[DOT_A];
      side_in.b    = dot_in[DOT_B];
      side_in.c    = dot_in[DOT_C];
      side_in.e    = dot_in[DOT_E];
      side_in.f    = dot_in[DOT_F];
      side_in.sel  = scp_pkg::SEL_S;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      r_ff    <= r_in;
      prod_ff <= prod_in;
      p0_2_ff <= p0_ff;
      p1_2_ff <= p1_ff;
      d1_2_ff <= d1_ff;
      d2_2_ff <= d2_ff;
      side_ff <= side_in;
   end

   assign out_valid = v3_ff;
   assign out_side  = side_ff;

endmodule

FILE: src/scp_cross.sv
// ----------------------------------------------------------------------------
// scp_cross: degenerate tests and the wide cross terms
// Partial products, then the four 136-bit products, then the unclamped
// numerator b*f - c*e and denominator a*e - b*b for s.
// ----------------------------------------------------------------------------
module scp_cross (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  scp_pkg::side_type               in_side,
   input  logic [scp_pkg::LIM_W-1:0]       limit,
   output logic                            out_valid,
   output logic signed [scp_pkg::QW-1:0]   out_num,
   output logic signed [scp_pkg::QW-1:0]   out_den,
   output scp_pkg::side_type               out_side
);

   logic v4_ff, v5_ff, v6_ff;
   logic [scp_pkg::DOT_W-1:0] lim;
   scp_pkg::side_type side4_in, side4_ff, side5_ff, side6_ff;
   scp_pkg::pp_type ae_pp_ff, bb_pp_ff, bf_pp_ff, ce_pp_ff;
   logic signed [scp_pkg::QW-1:0] ae_ff, bb_ff, bf_ff, ce_ff, num_ff, den_ff;

   // squared lengths are Q(2F), the limit is Q(F)
   assign lim = scp_pkg::DOT_W'({limit, {scp_pkg::FB{1'b0}}});

   always_comb begin
      side4_in      = in_side;
      side4_in.adeg = in_side.a <= lim;
      side4_in.edeg = in_side.e <= lim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      ae_pp_ff <= scp_pkg::wide_pp(in_side.a, in_side.e);
      bb_pp_ff <= scp_pkg::wide_pp(in_side.b, in_side.b);
      bf_pp_ff <= scp_pkg::wide_pp(in_side.b, in_side.f);
      ce_pp_ff <= scp_pkg::wide_pp(in_side.c, in_side.e);
      side4_ff <= side4_in;
      ae_ff    <= scp_pkg::wide_sum(ae_pp_ff);
      bb_ff    <= scp_pkg::wide_sum(bb_pp_ff);
      bf_ff    <= scp_pkg::wide_sum(bf_pp_ff);
      ce_ff    <= scp_pkg::wide_sum(ce_pp_ff);
      side5_ff <= side4_ff;
      den_ff   <= ae_ff - bb_ff;
      num_ff   <= bf_ff - ce_ff;
      side6_ff <= side5_ff;
   end

   assign out_valid = v6_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side6_ff;

endmodule

FILE: src/scp_div.sv
// ----------------------------------------------------------------------------
// scp_div: pipelined clamped divider
// clamp(num/den, 0, 1) in Q1.16, truncated; one range check stage followed
// by one restoring step per quotient bit.
// ----------------------------------------------------------------------------
module scp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [scp_pkg::QW-1:0] in_num,
   input  logic signed [scp_pkg::QW-1:0] in_den,
   input  scp_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [scp_pkg::PW-1:0]        out_q,
   output scp_pkg::side_type             out_side
);

   localparam int NS = scp_pkg::PB;

   logic [NS:0]                      v_ff, zero_ff, full_ff;
   logic [NS-1:0][scp_pkg::QW-1:0]   rem_ff, den_ff;
   logic [NS:0][NS-1:0]              q_ff;
   scp_pkg::side_type [NS:0]         side_ff;
   logic                             zero_in, full_in;
   logic [NS:1][scp_pkg::QW-1:0]     r2;
   logic [NS:1]                      ge;

   assign zero_in = (in_den <= 0) || (in_num <= 0);
   assign full_in = !zero_in && (in_num >= in_den);

   // remainder stays below den, so the doubled value still fits
   always_comb begin
      for (int k = 1; k <= NS; k++) begin
         r2[k] = {rem_ff[k-1][scp_pkg::QW-2:0], 1'b0};
         ge[k] = r2[k] >= den_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[NS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      zero_ff[0] <= zero_in;
      full_ff[0] <= full_in;
      rem_ff[0]  <= in_num;
      den_ff[0]  <= in_den;
      q_ff[0]    <= '0;
      side_ff[0] <= in_side;
      for (int k = 1; k < NS; k++) begin
         rem_ff[k] <= ge[k] ? r2[k] - den_ff[k-1] : r2[k];
         den_ff[k] <= den_ff[k-1];
      end
      for (int k = 1; k <= NS; k++) begin
         q_ff[k]    <= {q_ff[k-1][NS-2:0], ge[k]};
         zero_ff[k] <= zero_ff[k-1];
         full_ff[k] <= full_ff[k-1];
         side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_valid = v_ff[NS];
   assign out_q     = zero_ff[NS] ? '0 :
                      full_ff[NS] ? scp_pkg::PONE : {1'b0, q_ff[NS]};
   assign out_side  = side_ff[NS];

endmodule

FILE: src/scp_select.sv
// ----------------------------------------------------------------------------
// scp_select: derive t from the first s and pick the second division
// Computes b*s + f*2^16, tests it against e*2^16 and sets up the quotient
// that is still missing (s after a clamp of t, or t itself).
// ----------------------------------------------------------------------------
module scp_select (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [scp_pkg::PW-1:0]        in_q,
   input  scp_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic signed [scp_pkg::QW-1:0] out_num,
   output logic signed [scp_pkg::QW-1:0] out_den,
   output scp_pkg::side_type             out_side
);

   logic v1_ff, v2_ff, v3_ff;
   scp_pkg::side_type side1_in, side1_ff, side2_ff, side3_in, side3_ff;
   scp_pkg::pp_type   pp_ff;
   logic signed [scp_pkg::QW-1:0] nn_ff, e16_ff, num_in, den_in, num_ff, den_ff;
   logic signed [scp_pkg::QW-1:0] aw, bw, cw, ew, fw;

   always_comb begin
      side1_in   = in_side;
      side1_in.s = in_q;
   end

   always_comb begin
      aw = scp_pkg::QW'($signed(side2_ff.a));
      bw = scp_pkg::QW'($signed(side2_ff.b));
      cw = scp_pkg::QW'($signed(side2_ff.c));
      ew = scp_pkg::QW'($signed(side2_ff.e));
      fw = scp_pkg::QW'($signed(side2_ff.f));
      side3_in     = side2_ff;
      side3_in.sel = scp_pkg::SEL_S;
      num_in       = '0;
      den_in       = '0;
      if (side2_ff.adeg && side2_ff.edeg) begin
         // both points: a zero numerator yields s = 0
         side3_in.s = '0;
         side3_in.t = '0;
      end else if (side2_ff.adeg) begin
         side3_in.s   = '0;
         side3_in.sel = scp_pkg::SEL_T;
         num_in       = fw;
         den_in       = ew;
      end else if (side2_ff.edeg) begin
         side3_in.t = '0;
         num_in     = -cw;
         den_in     = aw;
      end else if (nn_ff < 0) begin
         side3_in.t = '0;
         num_in     = -cw;
         den_in     = aw;
      end else if (nn_ff > e16_ff) begin
         side3_in.t = scp_pkg::PONE;
         num_in     = bw - cw;
         den_in     = aw;
      end else begin
         side3_in.sel = scp_pkg::SEL_T;
         num_in       = nn_ff;
         den_in       = e16_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff    <= scp_pkg::wide_pp(in_side.b, scp_pkg::DOT_W'(in_q));
      side1_ff <= side1_in;
      nn_ff    <= scp_pkg::wide_sum(pp_ff)
                + (scp_pkg::QW'($signed(side1_ff.f)) <<< scp_pkg::PB);
      e16_ff   <= scp_pkg::QW'($signed(side1_ff.e)) <<< scp_pkg::PB;
      side2_ff <= side1_ff;
      num_ff   <= num_in;
      den_ff   <= den_in;
      side3_ff <= side3_in;
   end

   assign out_valid = v3_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side3_ff;

endmodule

FILE: src/scp_point.sv
// ----------------------------------------------------------------------------
// scp_point: final parameters and closest points
// Offsets |d|*s truncated toward zero, added to the start point and
// saturated to the coordinate range.
// ----------------------------------------------------------------------------
module scp_point (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [scp_pkg::PW-1:0] in_q,
   input  scp_pkg::side_type      in_side,
   output logic                   out_valid,
   output scp_pkg::rsp_type       out_rsp
);

   localparam int MW = scp_pkg::CW + scp_pkg::PW;
   localparam int VW = scp_pkg::CW + 2;

   logic v1_ff, v2_ff;
   logic [scp_pkg::PW-1:0] s_in, t_in, s_ff, t_ff;
   logic [2:0][MW-1:0] prod0_in, prod1_in, prod0_ff, prod1_ff;
   logic [2:0] neg0_in, neg1_in, neg0_ff, neg1_ff;
   logic [2:0][scp_pkg::DW-1:0] mag0, mag1;
   logic [2:0][scp_pkg::CW-1:0] p0_ff, p1_ff;
   logic [2:0][scp_pkg::CW-1:0] c0, c1;
   scp_pkg::rsp_type rsp_in, rsp_ff;

   function automatic logic [scp_pkg::CW-1:0] place(input logic [scp_pkg::CW-1:0] start,
                                                    input logic neg,
                                                    input logic [MW-1:0] prod);
      logic [VW-1:0] off;
      logic [VW-1:0] v;
      off = VW'(prod[MW-1:scp_pkg::PB]);
      v   = {{2{start[scp_pkg::CW-1]}}, start} + (neg ? -off : off);
      if (v[VW-1:scp_pkg::CW-1] == '0 || v[VW-1:scp_pkg::CW-1] == '1) begin
         return v[scp_pkg::CW-1:0];
      end else if (v[VW-1]) begin
         return {1'b1, {(scp_pkg::CW-1){1'b0}}};
      end else begin
         return {1'b0, {(scp_pkg::CW-1){1'b1}}};
      end
   endfunction

   always_comb begin
      s_in = (in_side.sel == scp_pkg::SEL_S) ? in_q : in_side.s;
      t_in = (in_side.sel == scp_pkg::SEL_T) ? in_q : in_side.t;
      for (int i = 0; i < 3; i++) begin
         neg0_in[i]  = in_side.d1[i][scp_pkg::DW-1];
         neg1_in[i]  = in_side.d2[i][scp_pkg::DW-1];
         mag0[i]     = neg0_in[i] ? -in_side.d1[i] : in_side.d1[i];
         mag1[i]     = neg1_in[i] ? -in_side.d2[i] : in_side.d2[i];
         prod0_in[i] = mag0[i][scp_pkg::CW-1:0] * s_in;
         prod1_in[i] = mag1[i][scp_pkg::CW-1:0] * t_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c0[i] = place(p0_ff[i], neg0_ff[i], prod0_ff[i]);
         c1[i] = place(p1_ff[i], neg1_ff[i], prod1_ff[i]);
      end
      rsp_in.closest0_x = c0[0];
      rsp_in.closest0_y = c0[1];
      rsp_in.closest0_z = c0[2];
      rsp_in.closest1_x = c1[0];
      rsp_in.closest1_y = c1[1];
      rsp_in.closest1_z = c1[2];
      rsp_in.param_s    = s_ff;
      rsp_in.param_t    = t_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      t_ff     <= t_in;
      prod0_ff <= prod0_in;
      prod1_ff <= prod1_in;
      neg0_ff  <= neg0_in;
      neg1_ff  <= neg1_in;
      p0_ff    <= in_side.p0;
      p1_ff    <= in_side.p1;
      rsp_ff   <= rsp_in;
   end

   assign out_valid = v2_ff;
   assign out_rsp   = rsp_ff;

endmodule
